// ===== hw/rtl/spbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbr_pkg: switch payload branch resolver package
// Beat types, format signatures and shared sizes.
// ----------------------------------------------------------------------------
package spbr_pkg;

    localparam logic [15:0] PACKED_MAGIC    = 16'h0100;
    localparam logic [15:0] SPARSE_MAGIC    = 16'h0200;
    localparam logic [31:0] NO_MATCH_OFFSET = 32'd3;
    localparam int          HALF_W          = 16;
    localparam int          IDX_W           = 18;
    localparam int          OUT_FIFO_DEPTH  = 3;

    typedef struct packed {
        logic [15:0]        code_unit;
        logic               start_req;
        logic signed [31:0] test_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] branch_offset;
        logic               found;
        logic               bad_magic;
    } t_out;

endpackage

// ===== hw/rtl/spbr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbr_core: payload walker
// Registers each code unit beat, tracks the payload format and match, and
// emits one result on the last unit of a payload or on a bad signature.
// ----------------------------------------------------------------------------
module spbr_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  spbr_pkg::t_in i_item,
    output logic          o_busy,
    output logic          o_res_valid,
    output spbr_pkg::t_out o_res
);
    import spbr_pkg::*;

    typedef enum logic [1:0] {MODE_IDLE, MODE_PACKED, MODE_SPARSE} t_mode;
    typedef enum logic [1:0] {MS_SEARCHING, MS_HIT, MS_MISS} t_match;

    logic               r_in_valid;
    t_in                r_in;
    t_mode              r_mode, n_mode;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [15:0]        r_cnt, n_cnt;
    logic [15:0]        r_held, n_held;
    logic [31:0]        r_tv, n_tv;
    logic [15:0]        r_mi, n_mi;
    t_match             r_ms, n_ms;
    logic [31:0]        r_chosen, n_chosen;

    logic [IDX_W-1:0]   idx_inc;
    logic [31:0]        word;
    logic [32:0]        diff;
    logic [IDX_W-1:0]   last_idx;
    logic [IDX_W-1:0]   keys_end;
    logic [IDX_W-1:0]   j_idx;
    logic               finish;

    assign idx_inc  = r_idx + IDX_W'(1);
    assign word     = {r_in.code_unit, r_held};
    assign diff     = {r_tv[31], r_tv} - {word[31], word};
    assign keys_end = IDX_W'(1) + {1'b0, r_cnt, 1'b0};

    always_comb begin
        last_idx = IDX_W'(3) + {1'b0, r_cnt, 1'b0};
        j_idx    = (idx_inc - IDX_W'(5)) >> 1;
        if (r_mode == MODE_SPARSE) begin
            last_idx = IDX_W'(1) + {r_cnt, 2'b00};
            if (idx_inc <= keys_end) begin
                j_idx = (idx_inc - IDX_W'(3)) >> 1;
            end else begin
                j_idx = (idx_inc - keys_end - IDX_W'(2)) >> 1;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_held   = r_held;
        n_tv     = r_tv;
        n_mi     = r_mi;
        n_ms     = r_ms;
        n_chosen = r_chosen;
        finish   = 1'b0;
        o_res_valid = 1'b0;
        o_res.branch_offset = NO_MATCH_OFFSET;
        o_res.found         = 1'b0;
        o_res.bad_magic     = 1'b0;
        if (r_in_valid) begin
            if (r_in.start_req) begin
                n_tv     = r_in.test_value;
                n_idx    = '0;
                n_cnt    = '0;
                n_held   = '0;
                n_mi     = '0;
                n_ms     = MS_SEARCHING;
                n_chosen = '0;
                priority if (r_in.code_unit == PACKED_MAGIC) begin
                    n_mode = MODE_PACKED;
                end else if (r_in.code_unit == SPARSE_MAGIC) begin
                    n_mode = MODE_SPARSE;
                end else begin
                    n_mode = MODE_IDLE;
                    o_res_valid     = 1'b1;
                    o_res.bad_magic = 1'b1;
                end
            end else if (r_mode != MODE_IDLE) begin
                n_idx = idx_inc;
                priority if (idx_inc == IDX_W'(1)) begin
                    n_cnt = r_in.code_unit;
                    if (r_mode == MODE_SPARSE && r_in.code_unit == 16'd0) begin
                        finish = 1'b1;
                    end
                end else if (!idx_inc[0]) begin
                    n_held = r_in.code_unit;
                end else begin
                    if (r_mode == MODE_PACKED && idx_inc == IDX_W'(3)) begin
                        // key window check in 33-bit signed arithmetic
                        if (!diff[32] && diff < {17'd0, r_cnt}) begin
                            n_ms = MS_HIT;
                            n_mi = diff[15:0];
                        end else begin
                            n_ms = MS_MISS;
                        end
                    end else if (r_mode == MODE_SPARSE && idx_inc <= keys_end) begin
                        if (r_ms == MS_SEARCHING) begin
                            if ($signed(word) == $signed(r_tv)) begin
                                n_ms = MS_HIT;
                                n_mi = j_idx[15:0];
                            end else if ($signed(word) > $signed(r_tv)) begin
                                n_ms = MS_MISS;
                            end
                        end
                    end else begin
                        if (r_ms == MS_HIT && j_idx == {2'b00, r_mi}) begin
                            n_chosen = word;
                        end
                    end
                    if (idx_inc == last_idx) begin
                        finish = 1'b1;
                    end
                end
                if (finish) begin
                    n_mode      = MODE_IDLE;
                    o_res_valid = 1'b1;
                    if (n_ms == MS_HIT) begin
                        o_res.branch_offset = n_chosen;
                        o_res.found         = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_held     <= '0;
            r_tv       <= '0;
            r_mi       <= '0;
            r_ms       <= MS_SEARCHING;
            r_chosen   <= '0;
        end else begin
            r_in_valid <= i_valid;
            r_mode     <= n_mode;
            r_idx      <= n_idx;
            r_cnt      <= n_cnt;
            r_held     <= n_held;
            r_tv       <= n_tv;
            r_mi       <= n_mi;
            r_ms       <= n_ms;
            r_chosen   <= n_chosen;
        end
    end

    assign o_busy = r_in_valid;

endmodule

// ===== hw/rtl/spbr_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbr_out_fifo: result buffer
// Small register FIFO that holds result beats until the sink takes them.
// ----------------------------------------------------------------------------
module spbr_out_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  spbr_pkg::t_out i_data,
    input  logic           i_pop,
    output logic           o_valid,
    output spbr_pkg::t_out o_data,
    output logic [$clog2(spbr_pkg::OUT_FIFO_DEPTH+1)-1:0] o_count
);
    import spbr_pkg::*;

    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    t_out             r_mem [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== hw/rtl/switch_payload_branch_resolver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_payload_branch_resolver_top: switch payload branch resolver
// Walks packed or sparse switch payloads one code unit beat at a time and
// returns the branch offset for the tested value.
// ----------------------------------------------------------------------------
// One code unit beat is taken every cycle while the input is ready. A beat is
// registered, resolved in the following cycle, and any result is written to a
// three-entry output FIFO. The input stays ready as long as the FIFO plus the
// beat in flight leave room for one more result; only a sink that holds off
// ready makes it drop.
module switch_payload_branch_resolver_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spbr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spbr_pkg::t_out o_out_data
);
    import spbr_pkg::*;

    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    logic             busy;
    logic             res_valid;
    t_out             res;
    logic [CNT_W-1:0] fifo_count;

    assign o_in_ready = ({1'b0, fifo_count} + (CNT_W+1)'(busy))
                        <= (CNT_W+1)'(OUT_FIFO_DEPTH - 1);

    spbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid && o_in_ready),
        .i_item      (i_in_data),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    spbr_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_count (fifo_count)
    );

endmodule

// ===== hw/rtl/spbr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbr_checker: port checks
// Concurrent checks on the resolver's ports, bound to the top level.
// ----------------------------------------------------------------------------
module spbr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input spbr_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input spbr_pkg::t_out o_out_data
);
    import spbr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_miss_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.branch_offset == NO_MATCH_OFFSET)
        else $error("miss without default offset");

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |-> !o_out_data.bad_magic)
        else $error("match flagged with bad signature");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind switch_payload_branch_resolver_top spbr_checker u_spbr_checker (.*);
